@@ src/rfg_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types of the residual fault test run grouper.
package rfg_pkg;

  localparam int unsigned TIME_BITS_DEF  = 48;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned VAR_W    = 32;
  localparam int unsigned CHI_W    = 24;
  localparam int unsigned GAP_W    = 32;
  localparam int unsigned MINC_W   = 16;
  localparam int unsigned MIND_W   = 32;
  localparam int unsigned SQ_W     = 2 * RES_W;
  localparam int unsigned RHS_W    = CHI_W + VAR_W;
  localparam int unsigned CHI_FRAC = 16;
  localparam int unsigned CMP_W    = SQ_W + CHI_FRAC;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CHI_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION  = 2'd3;

  // Chi-square limit for probability 0.99, one degree of freedom, in 1/65536.
  localparam logic [CHI_W-1:0]  CHI_THRESHOLD_RST = 24'd434825;
  localparam logic [GAP_W-1:0]  GAP_LIMIT_RST     = 32'd1000000;
  localparam logic [MINC_W-1:0] MIN_COUNT_RST     = 16'd1;
  localparam logic [MIND_W-1:0] MIN_DURATION_RST  = 32'd0;

  typedef enum logic [1:0] {
    KIND_VERDICT  = 2'd0,
    KIND_RETAINED = 2'd1,
    KIND_FILTERED = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  // Bit positions of the filter reason.
  localparam int unsigned REASON_FEW   = 0;
  localparam int unsigned REASON_SHORT = 1;

endpackage

@@ src/rfg_if.sv @@
`timescale 1ns / 1ps
// Observation and result channel interfaces of the run grouper.
interface rfg_obs_if #(
  parameter int unsigned TIME_BITS = rfg_pkg::TIME_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [rfg_pkg::ID_W-1:0]      tag_id;
  logic [rfg_pkg::ID_W-1:0]      anc_id;
  logic [TIME_BITS-1:0]          obs_time;
  logic signed [rfg_pkg::RES_W-1:0] residual;
  logic [rfg_pkg::VAR_W-1:0]     residual_variance;
  logic                          end_of_stream;

  modport source (
    output valid, tag_id, anc_id, obs_time, residual, residual_variance, end_of_stream,
    input  ready
  );
  modport sink (
    input  valid, tag_id, anc_id, obs_time, residual, residual_variance, end_of_stream,
    output ready
  );
endinterface

interface rfg_res_if #(
  parameter int unsigned TIME_BITS  = rfg_pkg::TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = rfg_pkg::COUNT_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic                     fault_flag;
  logic                     cand_flag;
  logic [rfg_pkg::ID_W-1:0] run_tag;
  logic [rfg_pkg::ID_W-1:0] run_anchor;
  logic [COUNT_BITS-1:0]    run_count;
  logic [TIME_BITS-1:0]     run_start;
  logic [TIME_BITS-1:0]     run_end;
  logic [1:0]               filter_reason;
  logic [COUNT_BITS-1:0]    run_ordinal;
  logic                     last_result;

  modport source (
    output valid, kind, fault_flag, cand_flag, run_tag, run_anchor, run_count,
           run_start, run_end, filter_reason, run_ordinal, last_result,
    input  ready
  );
  modport sink (
    input  valid, kind, fault_flag, cand_flag, run_tag, run_anchor, run_count,
           run_start, run_end, filter_reason, run_ordinal, last_result,
    output ready
  );
endinterface

@@ src/residual_fault_test_run_grouper.sv @@
`timescale 1ns / 1ps
// Chi-square residual fault test with grouping of candidate runs per link.
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------------
//  obs_i     | in        | tag, anchor, time, residual, variance, end of stream
//  res_o     | out       | verdict, rejection or closed run, last-result flag
//  cfg_*_i   | in        | write enable, register index, write data
//
// Each observation passes the input register and the product register; then its
// results load into the three result slots. It gives one to three results, drained
// one per cycle while res_o.ready is high; the next bundle loads as the last result
// of the one before leaves, so the result port sets the rate.
// Reset clears the pipeline, the open run, the ordinal and loads default limits.
// A stall on res_o backs up through the two pipeline registers to obs_i.ready.
module residual_fault_test_run_grouper #(
  parameter int unsigned TIME_BITS  = rfg_pkg::TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = rfg_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rfg_obs_if.sink                          obs_i,
  rfg_res_if.source                        res_o,
  input  logic                             cfg_we_i,
  input  logic [rfg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rfg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rfg_pkg::*;

  localparam int unsigned CW = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
  localparam int unsigned NW = (COUNT_BITS > MINC_W) ? COUNT_BITS : MINC_W;

  typedef struct packed {
    logic [ID_W-1:0]         tag;
    logic [ID_W-1:0]         anc;
    logic [TIME_BITS-1:0]    t;
    logic signed [RES_W-1:0] resid;
    logic [VAR_W-1:0]        vari;
    logic                    eos;
  } obs_t;

  typedef struct packed {
    logic [ID_W-1:0]      tag;
    logic [ID_W-1:0]      anc;
    logic [TIME_BITS-1:0] t;
    logic                 neg;
    logic                 rej;
    logic                 eos;
    logic [SQ_W-1:0]      sq;
    logic [RHS_W-1:0]     rhs;
  } prod_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  fault;
    logic                  cand;
    logic [ID_W-1:0]       tag;
    logic [ID_W-1:0]       anc;
    logic [COUNT_BITS-1:0] cnt;
    logic [TIME_BITS-1:0]  st;
    logic [TIME_BITS-1:0]  en;
    logic [1:0]            reason;
    logic [COUNT_BITS-1:0] ord;
    logic                  last;
  } res_t;

  function automatic res_t close_rec(input logic [ID_W-1:0] tag, input logic [ID_W-1:0] anc,
                                     input logic [COUNT_BITS-1:0] cnt,
                                     input logic [COUNT_BITS-1:0] ord,
                                     input logic [TIME_BITS-1:0] st,
                                     input logic [TIME_BITS-1:0] en,
                                     input logic [MINC_W-1:0] minc,
                                     input logic [MIND_W-1:0] mind);
    res_t                 r;
    logic [TIME_BITS-1:0] dur;
    logic [1:0]           why;
    dur = en - st;
    why = '0;
    why[REASON_FEW]   = NW'(cnt) < NW'(minc);
    why[REASON_SHORT] = CW'(dur) < CW'(mind);
    r        = '0;
    r.kind   = (why == 2'd0) ? KIND_RETAINED : KIND_FILTERED;
    r.tag    = tag;
    r.anc    = anc;
    r.cnt    = cnt;
    r.st     = st;
    r.en     = en;
    r.reason = why;
    r.ord    = (why == 2'd0) ? ord : '0;
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  // Configuration registers
  logic [CHI_W-1:0]  chi_q;
  logic [GAP_W-1:0]  gap_q;
  logic [MINC_W-1:0] minc_q;
  logic [MIND_W-1:0] mind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chi_q  <= CHI_THRESHOLD_RST;
      gap_q  <= GAP_LIMIT_RST;
      minc_q <= MIN_COUNT_RST;
      mind_q <= MIN_DURATION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHI_THRESHOLD: chi_q  <= cfg_data_i[CHI_W-1:0];
        REG_GAP_LIMIT:     gap_q  <= cfg_data_i[GAP_W-1:0];
        REG_MIN_COUNT:     minc_q <= cfg_data_i[MINC_W-1:0];
        REG_MIN_DURATION:  mind_q <= cfg_data_i[MIND_W-1:0];
        default:           chi_q  <= chi_q;
      endcase
    end
  end

  // Pipeline control
  logic       s1_v_q, s2_v_q;
  obs_t       s1_q;
  prod_t      s2_q, s2_d;
  logic [1:0] cnt_q;
  logic       out_fire, load, s2_rdy, s1_rdy;

  assign out_fire    = res_o.valid && res_o.ready;
  assign load        = s2_v_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire));
  assign s2_rdy      = !s2_v_q || load;
  assign s1_rdy      = !s1_v_q || s2_rdy;
  assign obs_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= obs_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obs_i.valid && s1_rdy) begin
      s1_q.tag   <= obs_i.tag_id;
      s1_q.anc   <= obs_i.anc_id;
      s1_q.t     <= obs_i.obs_time;
      s1_q.resid <= obs_i.residual;
      s1_q.vari  <= obs_i.residual_variance;
      s1_q.eos   <= obs_i.end_of_stream;
    end
    if (s1_v_q && s2_rdy) s2_q <= s2_d;
  end

  // Products of the chi-square test
  logic [RES_W-1:0] mag;

  always_comb begin
    mag      = s1_q.resid[RES_W-1] ? (~s1_q.resid) + RES_W'(1) : s1_q.resid;
    s2_d.tag = s1_q.tag;
    s2_d.anc = s1_q.anc;
    s2_d.t   = s1_q.t;
    s2_d.neg = s1_q.resid[RES_W-1];
    s2_d.rej = (s1_q.vari == '0);
    s2_d.eos = s1_q.eos;
    s2_d.sq  = SQ_W'(mag) * SQ_W'(mag);
    s2_d.rhs = RHS_W'(chi_q) * RHS_W'(s1_q.vari);
  end

  // Run state
  logic                  run_open_q;
  logic [ID_W-1:0]       open_tag_q, open_anc_q;
  logic [TIME_BITS-1:0]  open_st_q, last_t_q;
  logic [COUNT_BITS-1:0] open_cnt_q, ret_q;

  logic                  fault, cand, ext, close1, close2;
  logic [TIME_BITS-1:0]  gap;
  logic                  r1_open;
  logic [ID_W-1:0]       r1_tag, r1_anc;
  logic [TIME_BITS-1:0]  r1_st, r1_last;
  logic [COUNT_BITS-1:0] r1_cnt, ret1, ret_d;
  res_t                  verd, c1, c2;
  res_t                  new_res [3];
  logic [1:0]            n;

  always_comb begin
    fault  = {s2_q.sq, CHI_FRAC'(0)} > CMP_W'(s2_q.rhs);
    cand   = fault && s2_q.neg;
    gap    = s2_q.t - last_t_q;
    ext    = run_open_q && (open_tag_q == s2_q.tag) && (open_anc_q == s2_q.anc) &&
             (CW'(gap) <= CW'(gap_q));
    close1 = !s2_q.rej && run_open_q && !(cand && ext);

    verd       = '0;
    verd.kind  = s2_q.rej ? KIND_REJECTED : KIND_VERDICT;
    verd.fault = !s2_q.rej && fault;
    verd.cand  = !s2_q.rej && cand;

    c1   = close_rec(open_tag_q, open_anc_q, open_cnt_q, ret_q, open_st_q, last_t_q,
                     minc_q, mind_q);
    ret1 = (close1 && (c1.kind == KIND_RETAINED)) ? sat_inc(ret_q) : ret_q;

    r1_open = run_open_q;
    r1_tag  = open_tag_q;
    r1_anc  = open_anc_q;
    r1_st   = open_st_q;
    r1_last = last_t_q;
    r1_cnt  = open_cnt_q;
    if (!s2_q.rej) begin
      if (cand && ext) begin
        r1_cnt  = sat_inc(open_cnt_q);
        r1_last = s2_q.t;
      end else if (cand) begin
        r1_open = 1'b1;
        r1_tag  = s2_q.tag;
        r1_anc  = s2_q.anc;
        r1_st   = s2_q.t;
        r1_last = s2_q.t;
        r1_cnt  = COUNT_BITS'(1);
      end else begin
        r1_open = 1'b0;
      end
    end

    close2 = s2_q.eos && r1_open;
    c2     = close_rec(r1_tag, r1_anc, r1_cnt, ret1, r1_st, r1_last, minc_q, mind_q);
    // End of stream restarts the ordinal for the next stream.
    ret_d  = s2_q.eos ? '0 : ret1;

    n          = 2'd1 + 2'(close1) + 2'(close2);
    new_res[0] = verd;
    new_res[1] = close1 ? c1 : c2;
    new_res[2] = c2;
    new_res[0].last = (n == 2'd1);
    new_res[1].last = (n == 2'd2);
    new_res[2].last = (n == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      open_tag_q <= '0;
      open_anc_q <= '0;
      open_st_q  <= '0;
      last_t_q   <= '0;
      open_cnt_q <= '0;
      ret_q      <= '0;
    end else if (load) begin
      run_open_q <= r1_open && !s2_q.eos;
      open_tag_q <= r1_tag;
      open_anc_q <= r1_anc;
      open_st_q  <= r1_st;
      last_t_q   <= r1_last;
      open_cnt_q <= r1_cnt;
      ret_q      <= ret_d;
    end
  end

  // Result slots: load a whole bundle, then shift one out per transaction
  res_t res_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= n;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q[0] <= new_res[0];
      res_q[1] <= new_res[1];
      res_q[2] <= new_res[2];
    end else if (out_fire) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign res_o.valid         = (cnt_q != 2'd0);
  assign res_o.kind          = res_q[0].kind;
  assign res_o.fault_flag    = res_q[0].fault;
  assign res_o.cand_flag     = res_q[0].cand;
  assign res_o.run_tag       = res_q[0].tag;
  assign res_o.run_anchor    = res_q[0].anc;
  assign res_o.run_count     = res_q[0].cnt;
  assign res_o.run_start     = res_q[0].st;
  assign res_o.run_end       = res_q[0].en;
  assign res_o.filter_reason = res_q[0].reason;
  assign res_o.run_ordinal   = res_q[0].ord;
  assign res_o.last_result   = res_q[0].last;

  a_last_is_final_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_q[0].last) |-> (cnt_q == 2'd1))
    else $error("last result shown while more results are pending");

  a_bundle_opens_with_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (res_q[0].kind == KIND_VERDICT || res_q[0].kind == KIND_REJECTED))
    else $error("bundle does not start with a verdict or rejection");

  a_eos_clears_ordinal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && s2_q.eos) |=> (ret_q == '0 && !run_open_q))
    else $error("end of stream left a run open or an ordinal standing");

  a_open_run_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (open_cnt_q != '0))
    else $error("open run with zero count");

endmodule
